// ===== hw/rtl/order1_huffman_decoder_core_macros.svh =====
// Assertion macros for the checker file of the order-1 Huffman decoder.
// Needs nothing else; take it in by `include where assertions are written.
`ifndef ORDER1_HUFFMAN_DECODER_CORE_MACROS_SVH
`define ORDER1_HUFFMAN_DECODER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define O1HD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("o1hd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define O1HD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("o1hd assertion failed");

`endif

// ===== hw/rtl/o1hd_pkg.sv =====
// Shared types, codes and constants of the order-1 Huffman decoder.
// No dependencies; the interfaces, queue, engine, top level and bench refer to it by scoped names.
`timescale 1ns / 1ps

package o1hd_pkg;

    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int SYM_W            = 8;
    localparam int NODE_W           = 9;
    localparam int LEN_W            = 32;
    localparam int BITS_PER_BYTE    = 8;
    localparam int QUEUE_DEPTH      = 2;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_TREE_WR = 2'd0;
    localparam cmd_t CMD_ROOT_WR = 2'd1;
    localparam cmd_t CMD_START   = 2'd2;
    localparam cmd_t CMD_BYTE    = 2'd3;

    // One classified request waiting for the decode engine.
    typedef struct packed {
        cmd_t                 op;
        logic [SYM_W-1:0]     ctx;
        logic [NODE_W-1:0]    slot;    // {node[7:0], branch} inside one tree
        logic [NODE_W-1:0]    value;
        logic [LEN_W-1:0]     len;
        logic                 len_nz;
        logic [SYM_W-1:0]     data;
    } q_entry_t;

endpackage

// ===== hw/rtl/o1hd_if.sv =====
// Valid/ready channel interfaces of the order-1 Huffman decoder.
// Depends on o1hd_pkg for field widths.
`timescale 1ns / 1ps

interface o1hd_req_if;
    logic                          valid;
    logic                          ready;
    o1hd_pkg::cmd_t                command;
    logic [o1hd_pkg::SYM_W-1:0]    context_symbol;
    logic [o1hd_pkg::NODE_W-1:0]   tree_node;
    logic                          branch_bit;
    logic [o1hd_pkg::NODE_W-1:0]   entry_value;
    logic [o1hd_pkg::LEN_W-1:0]    block_length;
    logic [o1hd_pkg::SYM_W-1:0]    data_byte;

    modport source (
        output valid, command, context_symbol, tree_node, branch_bit,
               entry_value, block_length, data_byte,
        input  ready
    );
    modport sink (
        input  valid, command, context_symbol, tree_node, branch_bit,
               entry_value, block_length, data_byte,
        output ready
    );
endinterface

interface o1hd_sym_if;
    logic                        valid;
    logic                        ready;
    logic [o1hd_pkg::SYM_W-1:0]  symbol;
    logic                        last;

    modport source (output valid, symbol, last, input ready);
    modport sink (input valid, symbol, last, output ready);
endinterface

// ===== hw/rtl/o1hd_cmd_queue.sv =====
// Front end: accepts requests, classifies them and holds them in a short queue.
// Depends on o1hd_pkg and the o1hd_req_if interface.
`timescale 1ns / 1ps

module o1hd_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    o1hd_req_if.sink            req,
    output o1hd_pkg::q_entry_t  head,
    output logic                head_valid,
    input  logic                pop
);

    localparam int DEPTH = o1hd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    o1hd_pkg::q_entry_t store_reg [DEPTH];
    o1hd_pkg::q_entry_t entry;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               take;

    assign req.ready  = (count_reg != CNT_W'(DEPTH));
    assign push       = req.valid && req.ready;
    assign head_valid = (count_reg != '0);
    assign take       = pop && head_valid;
    assign head       = store_reg[rd_ptr_reg];

    // Classify: pack the tree slot and flag an empty block up front.
    always_comb
    begin
        entry        = '0;
        entry.op     = req.command;
        entry.ctx    = req.context_symbol;
        entry.slot   = {req.tree_node[o1hd_pkg::SYM_W-1:0], req.branch_bit};
        entry.value  = req.entry_value;
        entry.len    = req.block_length;
        entry.len_nz = (req.block_length != '0);
        entry.data   = req.data_byte;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// ===== hw/rtl/o1hd_decode_engine.sv =====
// Back end: owns the tree and root stores, walks the trees bit by bit and emits symbols.
// Depends on o1hd_pkg and the o1hd_sym_if interface.
`timescale 1ns / 1ps

module o1hd_decode_engine #(
    parameter int SYMBOL_COUNT = o1hd_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  o1hd_pkg::q_entry_t  head,
    input  logic                head_valid,
    output logic                pop,
    o1hd_sym_if.source          sym
);

    localparam int SYM_W      = o1hd_pkg::SYM_W;
    localparam int NODE_W     = o1hd_pkg::NODE_W;
    localparam int LEN_W      = o1hd_pkg::LEN_W;
    localparam int CTX_W      = $clog2(SYMBOL_COUNT);
    localparam int TREE_AW    = CTX_W + NODE_W;
    localparam int TREE_DEPTH = SYMBOL_COUNT * (1 << NODE_W);
    localparam int IDX_W      = $clog2(o1hd_pkg::BITS_PER_BYTE);
    localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(o1hd_pkg::BITS_PER_BYTE - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;
    localparam logic [1:0] ST_ROOT = 2'd3;

    logic [NODE_W-1:0] tree_mem [TREE_DEPTH];
    logic [NODE_W-1:0] root_mem [SYMBOL_COUNT];

    logic [1:0]        state_reg, state_next;
    logic [SYM_W-1:0]  ctx_reg, ctx_next;
    logic [SYM_W-1:0]  node_reg, node_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic              active_reg, active_next;
    logic [SYM_W-1:0]  bits_reg, bits_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]  out_sym_reg, out_sym_next;
    logic              out_last_reg, out_last_next;

    logic [NODE_W-1:0] tree_rdata_reg, root_rdata_reg;
    logic              tree_oor_reg, root_oor_reg;

    logic              tree_we, root_we, tree_re, root_re;
    logic [SYM_W-1:0]  rd_ctx, rd_node, root_rctx;
    logic              rd_bit;
    logic [NODE_W-1:0] tree_nxt, root_val;
    logic              out_free;
    logic              wr_in_range;

    assign sym.valid  = out_valid_reg;
    assign sym.symbol = out_sym_reg;
    assign sym.last   = out_last_reg;

    assign out_free    = !out_valid_reg || sym.ready;
    assign tree_nxt    = tree_oor_reg ? '0 : tree_rdata_reg;
    assign root_val    = root_oor_reg ? '0 : root_rdata_reg;
    assign wr_in_range = ({1'b0, head.ctx} < (SYM_W + 1)'(SYMBOL_COUNT));

    always_comb
    begin
        state_next     = state_reg;
        ctx_next       = ctx_reg;
        node_next      = node_reg;
        left_next      = left_reg;
        active_next    = active_reg;
        bits_next      = bits_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !sym.ready;
        out_sym_next   = out_sym_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        tree_we        = 1'b0;
        root_we        = 1'b0;
        tree_re        = 1'b0;
        root_re        = 1'b0;
        rd_ctx         = ctx_reg;
        rd_node        = node_reg;
        rd_bit         = bits_reg[1];
        root_rctx      = ctx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    unique case (head.op)
                        o1hd_pkg::CMD_TREE_WR:
                        begin
                            tree_we = wr_in_range;
                        end
                        o1hd_pkg::CMD_ROOT_WR:
                        begin
                            root_we = wr_in_range;
                        end
                        o1hd_pkg::CMD_START:
                        begin
                            ctx_next    = '0;
                            left_next   = head.len;
                            active_next = head.len_nz;
                            root_re     = 1'b1;
                            root_rctx   = '0;
                            state_next  = ST_INIT;
                        end
                        o1hd_pkg::CMD_BYTE:
                        begin
                            // drop bytes while no block is running
                            if (active_reg)
                            begin
                                bits_next  = head.data;
                                idx_next   = '0;
                                tree_re    = 1'b1;
                                rd_bit     = head.data[0];
                                state_next = ST_STEP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                node_next  = root_val[SYM_W-1:0];
                state_next = ST_IDLE;
            end
            ST_STEP:
            begin
                if (!tree_nxt[NODE_W-1])
                begin
                    // leaf: hold here until the output register frees up
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_sym_next   = tree_nxt[SYM_W-1:0];
                        out_last_next  = (left_reg == LEN_W'(1));
                        left_next      = left_reg - 1'b1;
                        ctx_next       = tree_nxt[SYM_W-1:0];
                        root_re        = 1'b1;
                        root_rctx      = tree_nxt[SYM_W-1:0];
                        state_next     = ST_ROOT;
                    end
                end
                else
                begin
                    node_next = tree_nxt[SYM_W-1:0];
                    if (idx_reg == LAST_BIT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        bits_next = bits_reg >> 1;
                        tree_re   = 1'b1;
                        rd_node   = tree_nxt[SYM_W-1:0];
                    end
                end
            end
            ST_ROOT:
            begin
                node_next = root_val[SYM_W-1:0];
                if (left_reg == '0)
                begin
                    active_next = 1'b0;
                    state_next  = ST_IDLE;
                end
                else if (idx_reg == LAST_BIT)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    bits_next  = bits_reg >> 1;
                    tree_re    = 1'b1;
                    rd_node    = root_val[SYM_W-1:0];
                    state_next = ST_STEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ctx_reg       <= '0;
            node_reg      <= '0;
            left_reg      <= '0;
            active_reg    <= 1'b0;
            bits_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctx_reg       <= ctx_next;
            node_reg      <= node_next;
            left_reg      <= left_next;
            active_reg    <= active_next;
            bits_reg      <= bits_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
    end

    // Tree store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (tree_we)
        begin
            tree_mem[{head.ctx[CTX_W-1:0], head.slot}] <= head.value;
        end
        if (tree_re)
        begin
            tree_rdata_reg <= tree_mem[TREE_AW'({rd_ctx[CTX_W-1:0], rd_node, rd_bit})];
            tree_oor_reg   <= ({1'b0, rd_ctx} >= (SYM_W + 1)'(SYMBOL_COUNT));
        end
    end

    // Root store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (root_we)
        begin
            root_mem[head.ctx[CTX_W-1:0]] <= head.value;
        end
        if (root_re)
        begin
            root_rdata_reg <= root_mem[root_rctx[CTX_W-1:0]];
            root_oor_reg   <= ({1'b0, root_rctx} >= (SYM_W + 1)'(SYMBOL_COUNT));
        end
    end

endmodule

// ===== hw/rtl/order1_huffman_decoder_core.sv =====
// Channel   Dir  Payload                                              Accepted when
// req       in   command, context_symbol, tree_node, branch_bit,      valid && ready
//                entry_value, block_length, data_byte
// sym       out  symbol, last                                         valid && ready
//
// Tree and root writes finish in the idle state that pops them; a block start also passes
// the init state. A compressed byte is popped in the idle state and walked bit by bit in
// the step state on registered tree store reads, each leaf adding a root store read.
// A two-entry request queue decouples the input side from the decode engine.
// A stalled output holds the engine on the pending leaf; the queue accepts until both
// of its entries are full, then drops ready.
// Reset clears control state only; tree and root stores are undefined until written.
//
// Top level of the order-1 Huffman decoder; depends on o1hd_pkg, o1hd_if,
// o1hd_cmd_queue and o1hd_decode_engine.
`timescale 1ns / 1ps

module order1_huffman_decoder_core #(
    parameter int SYMBOL_COUNT = o1hd_pkg::SYMBOL_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    o1hd_req_if.sink    req,
    o1hd_sym_if.source  sym
);

    o1hd_pkg::q_entry_t head;
    logic               head_valid;
    logic               pop;

    o1hd_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    o1hd_decode_engine #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .sym        (sym)
    );

endmodule

// ===== hw/rtl/o1hd_checker.sv =====
// Port-level checks of the order-1 Huffman decoder, bound to the top level.
// Depends on order1_huffman_decoder_core_macros.svh.
`timescale 1ns / 1ps
`include "order1_huffman_decoder_core_macros.svh"

module o1hd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       sym_valid,
    input logic       sym_ready,
    input logic [7:0] symbol,
    input logic       last
);

    // A stalled result holds its place and value.
    `O1HD_ASSERT_NEXT(a_sym_hold, clk, rst_n, sym_valid && !sym_ready, sym_valid && $stable(symbol) && $stable(last))

    // The queue only fills through an accepted request.
    `O1HD_ASSERT_SAME(a_ready_fall, clk, rst_n, $fell(req_ready), $past(req_valid))

    // Nothing is pending right after reset.
    `O1HD_ASSERT_SAME(a_quiet_reset, clk, rst_n, $rose(rst_n), !sym_valid && req_ready)

endmodule

bind order1_huffman_decoder_core o1hd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sym_valid (sym.valid),
    .sym_ready (sym.ready),
    .symbol    (sym.symbol),
    .last      (sym.last)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for order1_huffman_decoder_core: loads per-context code trees, runs blocks
// of compressed bytes and checks every decoded symbol against a shadow decoder kept in this file.
// Depends on o1hd_pkg and the o1hd_req_if / o1hd_sym_if channel interfaces.

module tb_top;

    // Contexts from NUM_SYMBOLS up are out of range: writes to them are dropped
    localparam int NUM_SYMBOLS = 240;
    localparam int LIVE_CTX    = 12;
    localparam int QUIET_LIMIT = 5000;

    typedef struct packed {
        o1hd_pkg::cmd_t command;
        logic [7:0]     context_symbol;
        logic [8:0]     tree_node;
        logic           branch_bit;
        logic [8:0]     entry_value;
        logic [31:0]    block_length;
        logic [7:0]     data_byte;
    } request_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } symbol_t;

    logic clk;
    logic rst_n;

    o1hd_req_if req_ch();
    o1hd_sym_if sym_ch();

    order1_huffman_decoder_core #(
        .SYMBOL_COUNT(NUM_SYMBOLS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .sym   (sym_ch)
    );

    // Shadow decoder state
    bit [8:0]  code_tree [0:131071];
    bit        tree_ok   [0:131071];
    bit [8:0]  ctx_root  [0:255];
    bit [8:0]  walk_node;
    bit [7:0]  walk_ctx;
    bit [31:0] symbols_left;
    bit        blk_active;
    symbol_t   pending_symbols[$];

    // Contexts that always hold a complete tree; every in-range leaf names one of them
    bit [7:0]  live_ctx [LIVE_CTX];

    int send_idle_pct = 9;
    int sink_idle_pct = 54;
    int hold_len = 0;
    int hold_seq = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic bit [8:0] child_of(bit [7:0] ctx, bit [8:0] node, bit br);
        if (ctx >= NUM_SYMBOLS)
            return 9'd0;
        return code_tree[{ctx, node[7:0], br}];
    endfunction

    function automatic bit [8:0] root_of(bit [7:0] ctx);
        if (ctx >= NUM_SYMBOLS)
            return 9'd0;
        return ctx_root[ctx];
    endfunction

    function automatic void decode_request(request_t r);
        bit [8:0] nxt;
        bit [7:0] ctx;
        ctx = r.context_symbol;
        case (r.command)
            o1hd_pkg::CMD_TREE_WR:
                if (ctx < NUM_SYMBOLS)
                begin
                    code_tree[{ctx, r.tree_node[7:0], r.branch_bit}] = r.entry_value;
                    tree_ok[{ctx, r.tree_node[7:0], r.branch_bit}] = 1'b1;
                end
            o1hd_pkg::CMD_ROOT_WR:
                if (ctx < NUM_SYMBOLS)
                    ctx_root[ctx] = r.entry_value;
            o1hd_pkg::CMD_START:
            begin
                walk_ctx = 8'd0;
                walk_node = root_of(8'd0);
                symbols_left = r.block_length;
                blk_active = (r.block_length != 32'd0);
            end
            default:
                for (int i = 0; i < o1hd_pkg::BITS_PER_BYTE; i++)
                begin
                    if (blk_active)
                    begin
                        nxt = child_of(walk_ctx, walk_node, r.data_byte[i]);
                        if (!nxt[8])
                        begin
                            pending_symbols.push_back('{nxt[7:0], symbols_left == 32'd1});
                            symbols_left--;
                            walk_ctx = nxt[7:0];
                            walk_node = root_of(nxt[7:0]);
                            if (symbols_left == 32'd0)
                                blk_active = 1'b0;
                        end
                        else
                            walk_node = nxt;
                    end
                end
        endcase
    endfunction

    task automatic send_request(input request_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.command        <= r.command;
        req_ch.context_symbol <= r.context_symbol;
        req_ch.tree_node      <= r.tree_node;
        req_ch.branch_bit     <= r.branch_bit;
        req_ch.entry_value    <= r.entry_value;
        req_ch.block_length   <= r.block_length;
        req_ch.data_byte      <= r.data_byte;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        decode_request(r);
    endtask

    // Fields a command does not use carry random values
    function automatic request_t noise_fields();
        request_t r;
        r.command        = o1hd_pkg::cmd_t'($urandom);
        r.context_symbol = 8'($urandom);
        r.tree_node      = 9'($urandom);
        r.branch_bit     = 1'($urandom);
        r.entry_value    = 9'($urandom);
        r.block_length   = $urandom;
        r.data_byte      = 8'($urandom);
        return r;
    endfunction

    task automatic tree_write(input bit [7:0] ctx, input bit [8:0] node, input bit br,
                              input bit [8:0] val);
        request_t r;
        r = noise_fields();
        r.command        = o1hd_pkg::CMD_TREE_WR;
        r.context_symbol = ctx;
        r.tree_node      = node;
        r.branch_bit     = br;
        r.entry_value    = val;
        send_request(r);
    endtask

    task automatic root_write(input bit [7:0] ctx, input bit [8:0] val);
        request_t r;
        r = noise_fields();
        r.command        = o1hd_pkg::CMD_ROOT_WR;
        r.context_symbol = ctx;
        r.entry_value    = val;
        send_request(r);
    endtask

    task automatic start_block(input bit [31:0] len);
        request_t r;
        r = noise_fields();
        r.command      = o1hd_pkg::CMD_START;
        r.block_length = len;
        send_request(r);
    endtask

    task automatic send_byte(input bit [7:0] data);
        request_t r;
        r = noise_fields();
        r.command   = o1hd_pkg::CMD_BYTE;
        r.data_byte = data;
        send_request(r);
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
    endtask

    // Address an internal node, now and then through its alias below 256
    function automatic bit [8:0] node_ref(bit [7:0] id);
        return {($urandom_range(4) != 0), id};
    endfunction

    function automatic bit [8:0] leaf_symbol();
        if ($urandom_range(99) < 15)
            return 9'($urandom_range(255, NUM_SYMBOLS));
        return {1'b0, live_ctx[$urandom_range(LIVE_CTX - 1)]};
    endfunction

    // Find a node of this context whose two children are both written
    function automatic bit [7:0] complete_node(bit [7:0] ctx);
        bit [7:0] id;
        id = 8'($urandom);
        for (int i = 0; i < 256; i++)
        begin
            if (tree_ok[{ctx, id, 1'b0}] && tree_ok[{ctx, id, 1'b1}])
                return id;
            id++;
        end
        return id;
    endfunction

    task automatic build_code_tree(input bit [7:0] ctx);
        bit [255:0] taken;
        bit [7:0]   inner[$];
        bit [7:0]   open_id[$];
        bit         open_br[$];
        bit [7:0]   id;
        int         n_leaves;
        int         pick;
        taken = '0;
        n_leaves = $urandom_range(8, 2);
        // go idle so that no byte walks a half-built tree
        if (blk_active)
            start_block(32'd0);
        while (inner.size() < n_leaves - 1)
        begin
            id = 8'($urandom);
            if (!taken[id])
            begin
                taken[id] = 1'b1;
                inner.push_back(id);
            end
        end
        open_id = '{inner[0], inner[0]};
        open_br = '{1'b0, 1'b1};
        for (int k = 1; k < inner.size(); k++)
        begin
            pick = $urandom_range(open_id.size() - 1);
            tree_write(ctx, node_ref(open_id[pick]), open_br[pick], {1'b1, inner[k]});
            open_id.delete(pick);
            open_br.delete(pick);
            open_id.push_back(inner[k]);
            open_id.push_back(inner[k]);
            open_br.push_back(1'b0);
            open_br.push_back(1'b1);
        end
        foreach (open_id[j])
            tree_write(ctx, node_ref(open_id[j]), open_br[j], leaf_symbol());
        root_write(ctx, {1'($urandom_range(3) != 0), inner[0]});
    endtask

    // Rewrite a root or a child so that every reachable entry stays written
    task automatic mutate_tree();
        bit [7:0] ctx;
        bit [8:0] val;
        ctx = live_ctx[$urandom_range(LIVE_CTX - 1)];
        if ($urandom_range(2) == 0)
            root_write(ctx, {1'($urandom), complete_node(ctx)});
        else
        begin
            val = ($urandom_range(1) != 0) ? leaf_symbol() : {1'b1, complete_node(ctx)};
            tree_write(ctx, node_ref(complete_node(ctx)), 1'($urandom), val);
        end
    endtask

    function automatic bit [31:0] block_size();
        int dice;
        dice = $urandom_range(99);
        if (dice < 5)
            return 32'd0;
        if (dice < 10)
            return $urandom;
        return 32'($urandom_range(30, 1));
    endfunction

    task automatic test_directed();
        tree_write(8'hFF, 9'h1FF, 1'b1, 9'h1FF);
        root_write(8'(NUM_SYMBOLS), 9'h000);
        tree_write(8'h00, 9'h1FF, 1'b0, 9'h000);
        tree_write(8'h00, 9'h1FF, 1'b1, 9'h100);
        // node number below 256 lands on the slot of node 256
        tree_write(8'h00, 9'h000, 1'b0, 9'(NUM_SYMBOLS - 1));
        tree_write(8'h00, 9'h100, 1'b1, 9'h0FF);
        tree_write(8'(NUM_SYMBOLS - 1), 9'h180, 1'b0, 9'h000);
        tree_write(8'(NUM_SYMBOLS - 1), 9'h180, 1'b1, 9'(NUM_SYMBOLS - 1));
        // leaf as root: decoding steps from node 0x180
        root_write(8'(NUM_SYMBOLS - 1), 9'h080);
        root_write(8'h00, 9'h1FF);
        start_block(32'd0);
        send_byte(8'hA5);
        start_block(32'd20);
        send_byte(8'h00);
        send_byte(8'hFF);
        // edit the live trees mid-block
        tree_write(8'h00, 9'h1FF, 1'b0, 9'(NUM_SYMBOLS - 1));
        root_write(8'h00, 9'h100);
        send_byte(8'h5A);
        send_byte(8'hFF);
        start_block(32'hFFFF_FFFF);
        send_byte(8'h96);
        start_block(32'd3);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_load_trees();
        for (int i = 0; i < LIVE_CTX; i++)
            build_code_tree(live_ctx[i]);
    endtask

    task automatic test_random_decode(input int n_items, input int send_pct, input int sink_pct);
        int sent;
        int dice;
        send_idle_pct = send_pct;
        sink_idle_pct = sink_pct;
        for (int i = 0; i < 3; i++)
            build_code_tree(live_ctx[$urandom_range(LIVE_CTX - 1)]);
        sent = 0;
        while (sent < n_items)
        begin
            dice = $urandom_range(99);
            if (dice < 5)
            begin
                if (!blk_active && dice < 3)
                    send_byte(8'($urandom));
                else if (dice < 4)
                    tree_write(8'($urandom_range(255, NUM_SYMBOLS)), 9'($urandom),
                               1'($urandom), 9'($urandom));
                else
                    root_write(8'($urandom_range(255, NUM_SYMBOLS)), 9'($urandom));
            end
            else
            begin
                sent++;
                if (dice < 10)
                    mutate_tree();
                else if (!blk_active || dice < 14)
                    start_block(block_size());
                else
                    send_byte(8'($urandom));
            end
        end
        pause_until_drained();
    endtask

    // Hold the symbol side off while bytes keep coming, so the request side backs up
    task automatic test_output_stall();
        hold_len = 300;
        hold_seq++;
        start_block(32'd200);
        for (int i = 0; i < 24; i++)
            send_byte(8'($urandom));
        pause_until_drained();
    endtask

    initial
    begin : sink_drive
        int hold_left;
        int seen_seq;
        hold_left = 0;
        seen_seq = 0;
        sym_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != seen_seq)
            begin
                seen_seq = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                sym_ch.ready <= 1'b0;
            end
            else
                sym_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_symbols
        symbol_t want;
        if (rst_n && sym_ch.valid && sym_ch.ready)
        begin
            if (pending_symbols.size() == 0)
            begin
                $display("%0t: symbol %02h last %0b with nothing expected",
                         $time, sym_ch.symbol, sym_ch.last);
                mismatches++;
            end
            else
            begin
                want = pending_symbols.pop_front();
                if (sym_ch.symbol !== want.symbol)
                begin
                    $display("%0t: symbol expected %02h got %02h",
                             $time, want.symbol, sym_ch.symbol);
                    mismatches++;
                end
                if (sym_ch.last !== want.last)
                begin
                    $display("%0t: last expected %0b got %0b", $time, want.last, sym_ch.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (sym_ch.valid && sym_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("order1_huffman_decoder_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = o1hd_pkg::CMD_TREE_WR;
        req_ch.context_symbol = 8'd0;
        req_ch.tree_node = 9'd0;
        req_ch.branch_bit = 1'b0;
        req_ch.entry_value = 9'd0;
        req_ch.block_length = 32'd0;
        req_ch.data_byte = 8'd0;
        live_ctx[0] = 8'h00;
        live_ctx[1] = 8'(NUM_SYMBOLS - 1);
        live_ctx[2] = 8'h10;
        for (int i = 3; i < LIVE_CTX; i++)
            live_ctx[i] = 8'($urandom_range(NUM_SYMBOLS - 1, 1));
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_load_trees();
        test_random_decode(70, 9, 54);
        test_random_decode(70, 54, 9);
        test_random_decode(70, 0, 0);
        test_output_stall();

        pause_until_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_symbols.size() == 0)
            $display("order1_huffman_decoder_core: match");
        else
            $display("order1_huffman_decoder_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/o1hd_pkg.sv
hw/rtl/o1hd_if.sv
hw/rtl/o1hd_cmd_queue.sv
hw/rtl/o1hd_decode_engine.sv
hw/rtl/order1_huffman_decoder_core.sv
hw/rtl/o1hd_checker.sv
tb/tb_top.sv
